FILE: rtl/ostmr_pkg.sv
// Shared types, register offsets and helpers for the OS timer block.
`default_nettype none
package ostmr_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 2;
    localparam int PSC_W     = 4;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE_EVENT = 1'b0,
        CFG_PRESCALE_FREE  = 1'b1
    } cfg_idx_t;

    // divider codes
    localparam logic [1:0] PSC_DIV4  = 2'd1;
    localparam logic [1:0] PSC_DIV16 = 2'd2;

    // register byte offsets
    localparam logic [ADDR_W-1:0] ADDR_PRESCALE = 8'h00;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE   = 8'h04;
    localparam logic [ADDR_W-1:0] ADDR_CLEAR    = 8'h08;
    localparam logic [ADDR_W-1:0] ADDR_FLAG     = 8'h0c;
    localparam logic [ADDR_W-1:0] ADDR_MASK     = 8'h10;
    localparam logic [ADDR_W-1:0] ADDR_FULL     = 8'h14;
    localparam logic [ADDR_W-1:0] ADDR_EV_COUNT = 8'h18;
    localparam logic [ADDR_W-1:0] ADDR_FREE_HI  = 8'h1c;
    localparam logic [ADDR_W-1:0] ADDR_FREE_LO  = 8'h20;
    localparam logic [ADDR_W-1:0] ADDR_LATCH    = 8'h24;
    localparam logic [ADDR_W-1:0] ADDR_EN_SET   = 8'h34;
    localparam logic [ADDR_W-1:0] ADDR_EN_CLR   = 8'h38;

    localparam logic [DATA_W:0] FULL_RESET = 33'h0_FFFF_FFFF;

    typedef struct packed {
        mode_t               mode;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } item_t;

    typedef struct packed {
        logic                irq;
        logic [DATA_W-1:0]   read_data;
    } result_t;

    // live state for checking
    typedef struct packed {
        logic [DATA_W-1:0]   event_count;
        logic [DATA_W:0]     full_value;
        logic                irq_level;
    } status_t;

    function automatic logic [PSC_W:0] divider_of(input logic [1:0] code);
        logic [PSC_W:0] div;
        unique case (code)
            PSC_DIV4:  div = 5'd4;
            PSC_DIV16: div = 5'd16;
            default:   div = 5'd1;
        endcase
        return div;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ostmr_prescaler.sv
// Tick prescaler: divides enabled reference ticks by 1, 4 or 16.
`default_nettype none
module ostmr_prescaler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       tick,     // enabled reference tick
    input  wire logic       restart,  // phase restart
    input  wire logic [1:0] code,
    output logic            fire
);
    import ostmr_pkg::*;

    logic [PSC_W-1:0] count_reg;
    logic [PSC_W-1:0] count_next;
    logic [PSC_W:0]   incr;

    always_comb
    begin
        incr       = {1'b0, count_reg} + {{PSC_W{1'b0}}, 1'b1};
        fire       = 1'b0;
        count_next = count_reg;
        if (restart)
        begin
            count_next = '0;
        end
        else if (tick)
        begin
            if (incr >= divider_of(code))
            begin
                fire       = 1'b1;
                count_next = '0;
            end
            else
            begin
                count_next = incr[PSC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule
`default_nettype wire

FILE: rtl/ostmr_regs.sv
// Timer state, register map and per-transaction update logic.
`default_nettype none
module ostmr_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ostmr_pkg::item_t            item,
    input  wire logic                        item_en,
    input  wire logic                        cfg_we,
    input  wire logic [ostmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ostmr_pkg::CFG_W-1:0] cfg_data,
    output ostmr_pkg::result_t               result,
    output ostmr_pkg::status_t               status
);
    import ostmr_pkg::*;

    logic [1:0]        psc_ev_reg,   psc_ev_next;
    logic [1:0]        psc_fr_reg,   psc_fr_next;
    logic [DATA_W-1:0] ev_count_reg, ev_count_next;
    logic [DATA_W:0]   full_reg,     full_next;
    logic              ev_en_reg,    ev_en_next;
    logic              fr_en_reg,    fr_en_next;
    logic              flag_reg,     flag_next;
    logic              mask_reg,     mask_next;
    logic [63:0]       free_reg,     free_next;
    logic [DATA_W-1:0] latch_reg,    latch_next;

    logic              is_tick;
    logic              ev_fire;
    logic              fr_fire;
    logic              fr_restart;
    logic [DATA_W:0]   ev_incr;
    logic [DATA_W-1:0] rd;

    assign is_tick = item_en && (item.mode == MODE_TICK);

    ostmr_prescaler u_psc_event (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (is_tick && ev_en_reg),
        .restart (1'b0),
        .code    (psc_ev_reg),
        .fire    (ev_fire)
    );

    ostmr_prescaler u_psc_free (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (is_tick && fr_en_reg),
        .restart (fr_restart),
        .code    (psc_fr_reg),
        .fire    (fr_fire)
    );

    always_comb
    begin
        psc_ev_next   = psc_ev_reg;
        psc_fr_next   = psc_fr_reg;
        ev_count_next = ev_count_reg;
        full_next     = full_reg;
        ev_en_next    = ev_en_reg;
        fr_en_next    = fr_en_reg;
        flag_next     = flag_reg;
        mask_next     = mask_reg;
        free_next     = free_reg;
        latch_next    = latch_reg;
        fr_restart    = 1'b0;
        rd            = '0;
        ev_incr       = {1'b0, ev_count_reg} + {{DATA_W{1'b0}}, 1'b1};

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRESCALE_EVENT: psc_ev_next = cfg_data;
                CFG_PRESCALE_FREE:  psc_fr_next = cfg_data;
            endcase
        end

        if (item_en)
        begin
            unique case (item.mode)
                MODE_TICK:
                begin
                    if (ev_fire)
                    begin
                        if (ev_incr >= full_reg)
                        begin
                            flag_next     = 1'b1;
                            ev_count_next = '0;
                        end
                        else
                        begin
                            ev_count_next = ev_incr[DATA_W-1:0];
                        end
                    end
                    if (fr_fire)
                        free_next = free_reg + 64'd1;
                end
                MODE_READ:
                begin
                    unique case (item.address)
                        ADDR_PRESCALE: rd = {28'd0, psc_fr_reg, psc_ev_reg};
                        ADDR_ENABLE:   rd = {30'd0, fr_en_reg, ev_en_reg};
                        ADDR_FLAG:     rd = {31'd0, flag_reg};
                        ADDR_MASK:     rd = {31'd0, mask_reg};
                        ADDR_FULL:     rd = full_reg[DATA_W-1:0];
                        ADDR_EV_COUNT: rd = ev_count_reg;
                        ADDR_FREE_HI:  rd = free_reg[63:32];
                        ADDR_FREE_LO:
                        begin
                            rd         = free_reg[31:0];
                            latch_next = free_reg[63:32];
                        end
                        ADDR_LATCH:    rd = latch_reg;
                        default:       rd = '0;
                    endcase
                end
                MODE_WRITE:
                begin
                    unique case (item.address)
                        ADDR_PRESCALE:
                        begin
                            psc_ev_next = item.write_data[1:0];
                            psc_fr_next = item.write_data[3:2];
                        end
                        ADDR_EN_SET:
                        begin
                            if (item.write_data[1] && !fr_en_reg)
                            begin
                                fr_en_next = 1'b1;
                                fr_restart = 1'b1;
                            end
                            if (item.write_data[0])
                                ev_en_next = 1'b1;
                        end
                        ADDR_EN_CLR:
                        begin
                            if (item.write_data[1])
                                fr_en_next = 1'b0;
                            if (item.write_data[0])
                                ev_en_next = 1'b0;
                        end
                        ADDR_CLEAR:
                        begin
                            if (item.write_data[1])
                            begin
                                free_next  = '0;
                                fr_restart = 1'b1;
                            end
                            if (item.write_data[0])
                                ev_count_next = '0;
                        end
                        ADDR_FLAG:     flag_next = 1'b0;
                        ADDR_MASK:     mask_next = item.write_data[0];
                        ADDR_FULL:
                        begin
                            full_next     = {1'b0, item.write_data} + {{DATA_W{1'b0}}, 1'b1};
                            ev_count_next = '0;
                        end
                        ADDR_EV_COUNT:
                        begin
                            // clamp to the compare value
                            if ({1'b0, item.write_data} < full_reg)
                                ev_count_next = item.write_data;
                            else
                                ev_count_next = full_reg[DATA_W-1:0];
                        end
                        ADDR_FREE_HI:
                        begin
                            free_next  = {item.write_data, free_reg[31:0]};
                            fr_restart = fr_en_reg;
                        end
                        ADDR_FREE_LO:
                        begin
                            free_next  = {free_reg[63:32], item.write_data};
                            fr_restart = fr_en_reg;
                        end
                        default: ;
                    endcase
                end
                MODE_NONE: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psc_ev_reg   <= '0;
            psc_fr_reg   <= '0;
            ev_count_reg <= '0;
            full_reg     <= FULL_RESET;
            ev_en_reg    <= 1'b0;
            fr_en_reg    <= 1'b0;
            flag_reg     <= 1'b0;
            mask_reg     <= 1'b1;
            free_reg     <= '0;
            latch_reg    <= '0;
        end
        else
        begin
            psc_ev_reg   <= psc_ev_next;
            psc_fr_reg   <= psc_fr_next;
            ev_count_reg <= ev_count_next;
            full_reg     <= full_next;
            ev_en_reg    <= ev_en_next;
            fr_en_reg    <= fr_en_next;
            flag_reg     <= flag_next;
            mask_reg     <= mask_next;
            free_reg     <= free_next;
            latch_reg    <= latch_next;
        end
    end

    // irq reflects the state after this transaction
    assign result.read_data = rd;
    assign result.irq       = flag_next && !mask_next && ev_en_next;

    assign status.event_count = ev_count_reg;
    assign status.full_value  = full_reg;
    assign status.irq_level   = flag_reg && !mask_reg && ev_en_reg;

endmodule
`default_nettype wire

FILE: rtl/os_timer_event_and_free_running_counter.sv
// Top level of the OS timer: input register, register-map update, result register.
// Path: an accepted transaction waits in the input register, then moves to the result register.
// Throughput: one transaction per cycle; the input register reloads whenever the result
//   register is empty or being taken, so both sides can stream without bubbles.
// Each transaction updates the timer state in the single cycle it moves to the result register.
// Reset (rst_n low, asynchronous): both stages empty, channels disabled, counts zero,
//   compare value 0xFFFFFFFF, flag clear, interrupt masked, prescalers divide by 1.
`default_nettype none
module os_timer_event_and_free_running_counter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave side
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [39:0]                      s_tdata,  // address[7:0], write_data[39:8]
    input  wire logic [1:0]                       s_tuser,  // mode[1:0]
    // master side
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [39:0]                           m_tdata,  // read_data[31:0], irq[32]
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [ostmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ostmr_pkg::CFG_W-1:0]      cfg_data
);
    import ostmr_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    status_t status;
    logic    advance;

    // move the held transaction forward when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.mode       <= mode_t'(s_tuser);
            in_item_reg.address    <= s_tdata[7:0];
            in_item_reg.write_data <= s_tdata[39:8];
        end
        if (advance)
            out_reg <= result;
    end

    ostmr_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_item_reg),
        .item_en   (advance),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .status    (status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.irq, out_reg.read_data};

    // event count never passes its compare value
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.event_count <= status.full_value[DATA_W-1:0]
        || status.full_value[DATA_W])
        else $error("event count above compare value");

    // compare value is never zero
    a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        status.full_value != '0)
        else $error("compare value is zero");

    // registered irq matches the state left by that transaction
    a_irq_level: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (m_tdata[32] == status.irq_level))
        else $error("irq does not match timer state");

    // a full result slot that is stalled blocks the input register from advancing
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire
